@@ src/lprc_pkg.sv @@
package lprc_pkg;

  localparam int TRIG_FRAC_BITS = 16;
  localparam int TRIG_SHIFT = 30 - TRIG_FRAC_BITS;
  localparam int MAX_DATAGRAM_BYTES = 1400;
  localparam int LAST_TERM = 5;

  localparam logic [10:0] MAX_BYTES = 11'(MAX_DATAGRAM_BYTES);
  localparam logic [10:0] HDR_BYTES = 11'd36;
  // radians per hundredth of a degree, q.40
  localparam logic [27:0] RAD_PER_CDEG = 28'd191900981;
  localparam logic [16:0] FULL_TURN = 17'd36000;
  localparam logic [16:0] QUARTER_TURN = 17'd9000;
  localparam logic [16:0] HALF_TURN = 17'd18000;
  localparam logic [16:0] THREE_QUARTER = 17'd27000;

  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_CART32 = 2'd1;
  localparam logic [1:0] FMT_CART16 = 2'd2;
  localparam logic [1:0] FMT_SPH = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_HEADER, OP_POINT, OP_ANGLE, OP_MUL_X, OP_SET_X, OP_MUL_X2, OP_SET_X2,
    OP_MUL_T, OP_MUL_RECIP, OP_MUL_QD, OP_FIX, OP_TRIG, OP_MUL_R, OP_SET_R,
    OP_MUL_XO, OP_SET_XO, OP_MUL_YO, OP_SET_YO, OP_MUL_ZO, OP_SET_ZO, OP_TIME, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] k;
    logic [1:0] ti;
  } cmd_t;

  typedef struct packed {
    logic result_go;
    logic spherical;
  } status_t;

  // taylor term divisors (2k+2)(2k+3)
  function automatic logic [7:0] series_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0: d = 8'd6;
      3'd1: d = 8'd20;
      3'd2: d = 8'd42;
      3'd3: d = 8'd72;
      3'd4: d = 8'd110;
      3'd5: d = 8'd156;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^s / d) with s = 32 + floor(log2 d)
  function automatic logic [31:0] series_recip(input logic [2:0] k);
    logic [31:0] m;
    case (k)
      3'd0: m = 32'd2863311530;
      3'd1: m = 32'd3435973836;
      3'd2: m = 32'd3272356035;
      3'd3: m = 32'd3817748707;
      3'd4: m = 32'd2498890063;
      3'd5: m = 32'd3524075730;
      default: m = 32'd2863311530;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] series_shift(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd0: s = 6'd34;
      3'd1: s = 6'd36;
      3'd2: s = 6'd37;
      3'd3: s = 6'd38;
      3'd4: s = 6'd38;
      3'd5: s = 6'd39;
      default: s = 6'd34;
    endcase
    return s;
  endfunction

endpackage

@@ src/lprc_ctrl.sv @@
module lprc_ctrl
  import lprc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    kind,
  input  logic    m_tready,
  input  status_t status,
  output logic    s_tready,
  output logic    m_tvalid,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANGLE, ST_MUL_X, ST_SET_X, ST_MUL_X2, ST_SET_X2, ST_MUL_T, ST_MUL_RECIP,
    ST_MUL_QD, ST_FIX, ST_TRIG, ST_MUL_R, ST_SET_R, ST_MUL_XO, ST_SET_XO, ST_MUL_YO,
    ST_SET_YO, ST_MUL_ZO, ST_SET_ZO, ST_TIME, ST_DONE
  } state_t;

  state_t     state;
  logic [2:0] k;
  logic [1:0] ti;
  logic       out_valid;
  logic       emit_ok;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign emit_ok = !out_valid || m_tready;
  assign cmd.k = k;
  assign cmd.ti = ti;

  always_comb begin
    case (state)
      ST_IDLE:      cmd.op = s_tvalid ? (kind ? OP_POINT : OP_HEADER) : OP_NONE;
      ST_ANGLE:     cmd.op = OP_ANGLE;
      ST_MUL_X:     cmd.op = OP_MUL_X;
      ST_SET_X:     cmd.op = OP_SET_X;
      ST_MUL_X2:    cmd.op = OP_MUL_X2;
      ST_SET_X2:    cmd.op = OP_SET_X2;
      ST_MUL_T:     cmd.op = OP_MUL_T;
      ST_MUL_RECIP: cmd.op = OP_MUL_RECIP;
      ST_MUL_QD:    cmd.op = OP_MUL_QD;
      ST_FIX:       cmd.op = OP_FIX;
      ST_TRIG:      cmd.op = OP_TRIG;
      ST_MUL_R:     cmd.op = OP_MUL_R;
      ST_SET_R:     cmd.op = OP_SET_R;
      ST_MUL_XO:    cmd.op = OP_MUL_XO;
      ST_SET_XO:    cmd.op = OP_SET_XO;
      ST_MUL_YO:    cmd.op = OP_MUL_YO;
      ST_SET_YO:    cmd.op = OP_SET_YO;
      ST_MUL_ZO:    cmd.op = OP_MUL_ZO;
      ST_SET_ZO:    cmd.op = OP_SET_ZO;
      ST_TIME:      cmd.op = OP_TIME;
      ST_DONE:      cmd.op = emit_ok ? OP_EMIT : OP_NONE;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= '0;
      ti <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && emit_ok) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && kind && status.result_go) begin
            state <= status.spherical ? ST_ANGLE : ST_TIME;
            ti <= '0;
          end
        end
        ST_ANGLE:     state <= ST_MUL_X;
        ST_MUL_X:     state <= ST_SET_X;
        ST_SET_X:     state <= ST_MUL_X2;
        ST_MUL_X2:    state <= ST_SET_X2;
        ST_SET_X2: begin
          state <= ST_MUL_T;
          k <= '0;
        end
        ST_MUL_T:     state <= ST_MUL_RECIP;
        ST_MUL_RECIP: state <= ST_MUL_QD;
        ST_MUL_QD:    state <= ST_FIX;
        ST_FIX: begin
          if (k == 3'(LAST_TERM)) begin
            state <= ST_TRIG;
          end else begin
            k <= k + 3'd1;
            state <= ST_MUL_T;
          end
        end
        ST_TRIG: begin
          if (ti == 2'd3) begin
            state <= ST_MUL_R;
          end else begin
            ti <= ti + 2'd1;
            state <= ST_ANGLE;
          end
        end
        ST_MUL_R:     state <= ST_SET_R;
        ST_SET_R:     state <= ST_MUL_XO;
        ST_MUL_XO:    state <= ST_SET_XO;
        ST_SET_XO:    state <= ST_MUL_YO;
        ST_MUL_YO:    state <= ST_SET_YO;
        ST_SET_YO:    state <= ST_MUL_ZO;
        ST_MUL_ZO:    state <= ST_SET_ZO;
        ST_SET_ZO:    state <= ST_TIME;
        ST_TIME:      state <= ST_DONE;
        ST_DONE: begin
          if (emit_ok) begin
            state <= ST_IDLE;
          end
        end
        default:      state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/lprc_dp.sv @@
module lprc_dp
  import lprc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               kind,
  input  logic [7:0]         coord_format,
  input  logic [15:0]        point_spacing_ns,
  input  logic [15:0]        point_count,
  input  logic [10:0]        datagram_bytes,
  input  logic [63:0]        header_time_ns,
  input  logic [31:0]        word_a,
  input  logic [31:0]        word_b,
  input  logic [31:0]        word_c,
  input  logic [7:0]         reflect_level,
  input  logic [7:0]         point_tag,
  output status_t            status,
  output logic signed [32:0] x_mm,
  output logic signed [32:0] y_mm,
  output logic signed [32:0] z_mm,
  output logic [7:0]         brightness,
  output logic [63:0]        point_time_ns,
  output logic [31:0]        offset_ns
);

  // packet state
  logic [1:0]  pkt_fmt;
  logic        pkt_ok;
  logic [15:0] spacing;
  logic [63:0] base_time;
  logic [15:0] count;
  logic [15:0] npn;

  // point work registers
  logic [31:0] depth;
  logic [15:0] theta;
  logic [15:0] phi;
  logic [32:0] x_res, y_res, z_res;
  logic [7:0]  bright_res;
  logic [31:0] off_res;
  logic [63:0] time_res;

  // sine engine
  logic [13:0] ang;
  logic [3:0]  neg;
  logic [31:0] xq, x2, term, sum, n, q, r;
  logic [31:0] trig [4];
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;

  // header check
  logic [1:0]  fmt_code;
  logic [4:0]  rec;
  logic [10:0] bytes_c;
  logic [20:0] need;
  logic        hdr_ok;
  logic        pt_take;

  always_comb begin
    case (coord_format)
      8'(FMT_CART32): begin fmt_code = FMT_CART32; rec = 5'd14; end
      8'(FMT_CART16): begin fmt_code = FMT_CART16; rec = 5'd8; end
      8'(FMT_SPH):    begin fmt_code = FMT_SPH; rec = 5'd10; end
      default:        begin fmt_code = FMT_NONE; rec = 5'd0; end
    endcase
    bytes_c = (datagram_bytes > MAX_BYTES) ? MAX_BYTES : datagram_bytes;
    need = 21'(point_count) * 21'(rec);
    hdr_ok = (fmt_code != FMT_NONE) && (bytes_c >= HDR_BYTES) &&
             (21'(bytes_c - HDR_BYTES) >= need);
  end

  assign pt_take = kind && pkt_ok && (pkt_fmt != FMT_NONE) && (npn < count);
  assign status.result_go = pt_take && (point_tag[5:0] == 6'd0);
  assign status.spherical = (pkt_fmt == FMT_SPH);

  // angle reduction to a first-quadrant offset
  logic [16:0] a0, a1, rr;
  logic [13:0] ang_next;
  logic        neg_next;
  always_comb begin
    a0 = {1'b0, (cmd.ti[1] ? phi : theta)};
    if (a0 >= FULL_TURN) a0 = a0 - FULL_TURN;
    a1 = a0 + (cmd.ti[0] ? QUARTER_TURN : 17'd0);
    if (a1 >= FULL_TURN) a1 = a1 - FULL_TURN;
    if (a1 >= THREE_QUARTER) begin
      rr = QUARTER_TURN - (a1 - THREE_QUARTER);
      neg_next = 1'b1;
    end else if (a1 >= HALF_TURN) begin
      rr = a1 - HALF_TURN;
      neg_next = 1'b1;
    end else if (a1 >= QUARTER_TURN) begin
      rr = QUARTER_TURN - (a1 - QUARTER_TURN);
      neg_next = 1'b0;
    end else begin
      rr = a1;
      neg_next = 1'b0;
    end
    ang_next = rr[13:0];
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_MUL_X:     begin mul_a = 32'(ang); mul_b = 32'(RAD_PER_CDEG); end
      OP_MUL_X2:    begin mul_a = xq; mul_b = xq; end
      OP_MUL_T:     begin mul_a = term; mul_b = x2; end
      OP_MUL_RECIP: begin mul_a = prod[61:30]; mul_b = series_recip(cmd.k); end
      OP_MUL_QD:    begin
        mul_a = 32'(prod >> series_shift(cmd.k));
        mul_b = 32'(series_div(cmd.k));
      end
      OP_MUL_R:     begin mul_a = depth; mul_b = trig[0]; end
      OP_MUL_XO:    begin mul_a = r; mul_b = trig[3]; end
      OP_MUL_YO:    begin mul_a = r; mul_b = trig[2]; end
      OP_MUL_ZO:    begin mul_a = depth; mul_b = trig[1]; end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  logic [63:0] rnd_prod;
  logic [32:0] mag;
  logic [31:0] rem;
  logic [31:0] term_new;
  logic [32:0] trig_sum;
  assign rnd_prod = (prod + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
  assign mag = rnd_prod[32:0];
  assign rem = n - prod[31:0];
  assign term_new = q + 32'(rem >= 32'(series_div(cmd.k)));
  assign trig_sum = ({1'b0, sum} + (33'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_fmt <= FMT_NONE;
      pkt_ok <= 1'b0;
      count <= '0;
      npn <= '0;
    end else if (cmd.op == OP_HEADER) begin
      pkt_fmt <= fmt_code;
      pkt_ok <= hdr_ok;
      count <= point_count;
      npn <= '0;
    end else if (cmd.op == OP_POINT && pt_take) begin
      npn <= npn + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_HEADER: begin
        spacing <= point_spacing_ns;
        base_time <= header_time_ns;
      end
      OP_POINT: begin
        bright_res <= reflect_level;
        off_res <= 32'(spacing) * 32'(npn);
        depth <= word_a;
        theta <= word_b[15:0];
        phi <= word_c[15:0];
        if (pkt_fmt == FMT_CART32) begin
          x_res <= {word_a[31], word_a};
          y_res <= {word_b[31], word_b};
          z_res <= {word_c[31], word_c};
        end else begin
          x_res <= {{17{word_a[15]}}, word_a[15:0]};
          y_res <= {{17{word_b[15]}}, word_b[15:0]};
          z_res <= {{17{word_c[15]}}, word_c[15:0]};
        end
      end
      OP_ANGLE: begin
        ang <= ang_next;
        neg[cmd.ti] <= neg_next;
      end
      OP_SET_X: begin
        xq <= 32'((prod + 64'd512) >> 10);
        term <= 32'((prod + 64'd512) >> 10);
        sum <= 32'((prod + 64'd512) >> 10);
      end
      OP_SET_X2: x2 <= 32'((prod + (64'd1 << 29)) >> 30);
      OP_MUL_RECIP: n <= prod[61:30];
      OP_MUL_QD: q <= 32'(prod >> series_shift(cmd.k));
      OP_FIX: begin
        term <= term_new;
        sum <= cmd.k[0] ? sum + term_new : sum - term_new;
      end
      OP_TRIG: trig[cmd.ti] <= trig_sum[31:0];
      OP_SET_R: r <= rnd_prod[31:0];
      OP_SET_XO: x_res <= (neg[0] ^ neg[3]) ? 33'd0 - mag : mag;
      OP_SET_YO: y_res <= (neg[0] ^ neg[2]) ? 33'd0 - mag : mag;
      OP_SET_ZO: z_res <= neg[1] ? 33'd0 - mag : mag;
      OP_TIME: time_res <= base_time + 64'(off_res);
      OP_EMIT: begin
        x_mm <= x_res;
        y_mm <= y_res;
        z_mm <= z_res;
        brightness <= bright_res;
        point_time_ns <= time_res;
        offset_ns <= off_res;
      end
      default: ;
    endcase
    prod <= 64'(mul_a) * 64'(mul_b);
  end

endmodule

@@ src/lidar_point_record_converter_core.sv @@
// channel  dir  tuser   tdata fields (lsb first)
// s_*      in   kind    coord_format, spacing, count, datagram bytes, time, words a b c,
//                       reflect, tag
// m_*      out  -       x_mm, y_mm, z_mm, brightness, point_time_ns, offset_ns
//
// a header beat is taken in idle. a cartesian point then goes to the time and done
// steps; a spherical point first runs four sine evaluations of 30 steps each on one
// shared 32x32 multiplier, then four rounded products. after reset no packet is open
// and points are dropped. a result waits in the output register; the next beat is
// taken meanwhile, and its result waits at the last step until that register is free.
module lidar_point_record_converter_core
  import lprc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic         s_tuser,   // kind
  // coord_format, point_spacing_ns, point_count, datagram_bytes, header_time_ns,
  // word_a, word_b, word_c, reflect_level, point_tag
  input  logic [231:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // x_mm, y_mm, z_mm, brightness, point_time_ns, offset_ns
  output logic [207:0] m_tdata
);

  cmd_t    cmd;
  status_t status;

  logic signed [32:0] x_mm, y_mm, z_mm;
  logic [7:0]  brightness;
  logic [63:0] point_time_ns;
  logic [31:0] offset_ns;

  lprc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .m_tready (m_tready),
    .status   (status),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  lprc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .kind             (s_tuser),
    .coord_format     (s_tdata[7:0]),
    .point_spacing_ns (s_tdata[23:8]),
    .point_count      (s_tdata[39:24]),
    .datagram_bytes   (s_tdata[50:40]),
    .header_time_ns   (s_tdata[114:51]),
    .word_a           (s_tdata[146:115]),
    .word_b           (s_tdata[178:147]),
    .word_c           (s_tdata[210:179]),
    .reflect_level    (s_tdata[218:211]),
    .point_tag        (s_tdata[226:219]),
    .status           (status),
    .x_mm             (x_mm),
    .y_mm             (y_mm),
    .z_mm             (z_mm),
    .brightness       (brightness),
    .point_time_ns    (point_time_ns),
    .offset_ns        (offset_ns)
  );

  assign m_tdata = {5'd0, offset_ns, point_time_ns, brightness, z_mm, y_mm, x_mm};

  // a header beat never holds the input side
  a_hdr_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("header beat held the input");

  // output register is loaded only when free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> !m_tvalid || m_tready)
    else $error("pending result overwritten");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.op) == OP_EMIT)
    else $error("result shown without emit");

endmodule
